// ===== rtl/lrm_pkg.sv =====
package lrm_pkg;

  localparam int unsigned LINK_COUNT = 64;
  localparam int unsigned LINK_W     = $clog2(LINK_COUNT);
  localparam int unsigned BYTE_W     = 64;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned CAP_W      = 20;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned UTIL_W     = 17;
  localparam int unsigned ENTRY_W    = 2 * BYTE_W + TIME_W;

  // Q.8 rate: dividend is delta << 11 (3 for bits-per-byte, 8 fraction bits)
  localparam int unsigned RATE_SHIFT = 11;
  // top dividend bits that must stay below the divisor for a 32-bit quotient
  localparam int unsigned HI_W       = BYTE_W + RATE_SHIFT - RATE_W;
  localparam int unsigned CNT_W      = $clog2(RATE_W);

  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [UTIL_W-1:0] UTIL_ONE = UTIL_W'(65536);

endpackage

// ===== rtl/link_rate_meter_unit.sv =====
// Sequence: an input beat reads the sample memory (S_READ), then sets up (S_SETUP).
// With no usable earlier sample it goes to S_DONE; else it runs 32 rate steps of two
// restoring dividers (rx, tx) and, unless capacity is zero, 17 utilization steps on
// the rx divider, one quotient bit per cycle. One item in flight; the next input
// beat is taken the cycle after the result moves to the output register.
// Reset clears all per-link valid bits at once; the count/time memory is not cleared.
module link_rate_meter_unit import lrm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [LINK_W-1:0] link_index_i,
  input  logic [BYTE_W-1:0] rx_byte_count_i,
  input  logic [BYTE_W-1:0] tx_byte_count_i,
  input  logic [TIME_W-1:0] sample_time_us_i,
  input  logic [CAP_W-1:0]  capacity_mbps_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LINK_W-1:0] link_out_o,
  output logic [RATE_W-1:0] rx_rate_o,
  output logic [RATE_W-1:0] tx_rate_o,
  output logic [UTIL_W-1:0] utilization_o,
  output logic              rate_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SETUP,
    S_RATE,
    S_USETUP,
    S_UTIL,
    S_DONE
  } state_e;

  state_e state_q;

  logic [LINK_W-1:0]     link_q;
  logic [BYTE_W-1:0]     rx_q, tx_q;
  logic [TIME_W-1:0]     time_q;
  logic [CAP_W-1:0]      cap_q;

  logic [ENTRY_W-1:0]    mem_q [LINK_COUNT];
  logic [ENTRY_W-1:0]    rd_q;
  logic [LINK_COUNT-1:0] entry_valid_q;

  logic [BYTE_W-1:0]     drx_q, dtx_q;
  logic                  ok_q;
  logic [TIME_W-1:0]     dvs_q;
  logic [TIME_W-1:0]     rem_a_q, rem_b_q;
  logic [RATE_W-1:0]     sh_a_q, sh_b_q;
  logic [RATE_W-1:0]     q_a_q, q_b_q;
  logic                  ovf_a_q, ovf_b_q, ovf_u_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [RATE_W-1:0]     rx_rate_q, tx_rate_q;
  logic                  util_zero_q;

  logic                  in_accept;
  logic                  out_load;
  logic [BYTE_W-1:0]     old_rx, old_tx;
  logic [TIME_W-1:0]     old_time;
  logic [TIME_W:0]       step_a, step_b;
  logic [RATE_W-1:0]     rx_rate_d, tx_rate_d;
  logic [RATE_W:0]       rate_sum;
  logic [UTIL_W-1:0]     util_d;

  // one restoring-division step: returns {quotient bit, next remainder}
  function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] rem,
                                                input logic              bin,
                                                input logic [TIME_W-1:0] dvs);
    logic [TIME_W:0] r2;
    logic            ge;
    r2 = {rem, bin};
    ge = (r2 >= {1'b0, dvs});
    if (ge) begin
      r2 = r2 - {1'b0, dvs};
    end
    return {ge, r2[TIME_W-1:0]};
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_o || out_ready_i);

  assign {old_rx, old_tx, old_time} = rd_q;

  assign step_a = div_step(rem_a_q, sh_a_q[RATE_W-1], dvs_q);
  assign step_b = div_step(rem_b_q, sh_b_q[RATE_W-1], dvs_q);

  assign rx_rate_d = ovf_a_q ? RATE_MAX : q_a_q;
  assign tx_rate_d = ovf_b_q ? RATE_MAX : q_b_q;
  assign rate_sum  = {1'b0, rx_rate_d} + {1'b0, tx_rate_d};

  always_comb begin
    if (util_zero_q) begin
      util_d = '0;
    end else if (ovf_u_q || (q_a_q[UTIL_W-1:0] > UTIL_ONE)) begin
      util_d = UTIL_ONE;
    end else begin
      util_d = q_a_q[UTIL_W-1:0];
    end
  end

  // sample memory: read on the input beat, written back in the following cycle (S_READ)
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      mem_q[link_q] <= {rx_q, tx_q, time_q};
    end
    if (in_accept) begin
      rd_q <= mem_q[link_index_i];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          link_q <= link_index_i;
          rx_q   <= rx_byte_count_i;
          tx_q   <= tx_byte_count_i;
          time_q <= sample_time_us_i;
          cap_q  <= capacity_mbps_i;
        end
      end
      S_READ: begin
        dvs_q <= time_q - old_time;
        drx_q <= (rx_q >= old_rx) ? rx_q - old_rx : '0;
        dtx_q <= (tx_q >= old_tx) ? tx_q - old_tx : '0;
        ok_q  <= entry_valid_q[link_q] && (time_q > old_time);
      end
      S_SETUP: begin
        if (ok_q) begin
          // quotient fits 32 bits only if the top dividend bits are below the divisor
          ovf_a_q <= (TIME_W'(drx_q[BYTE_W-1:RATE_W-RATE_SHIFT]) >= dvs_q);
          ovf_b_q <= (TIME_W'(dtx_q[BYTE_W-1:RATE_W-RATE_SHIFT]) >= dvs_q);
          rem_a_q <= TIME_W'(drx_q[BYTE_W-1:RATE_W-RATE_SHIFT]);
          rem_b_q <= TIME_W'(dtx_q[BYTE_W-1:RATE_W-RATE_SHIFT]);
          sh_a_q  <= {drx_q[RATE_W-RATE_SHIFT-1:0], RATE_SHIFT'(0)};
          sh_b_q  <= {dtx_q[RATE_W-RATE_SHIFT-1:0], RATE_SHIFT'(0)};
          q_a_q   <= '0;
          q_b_q   <= '0;
          cnt_q   <= CNT_W'(RATE_W - 1);
        end else begin
          rx_rate_q   <= '0;
          tx_rate_q   <= '0;
          util_zero_q <= 1'b1;
        end
      end
      S_RATE: begin
        rem_a_q <= step_a[TIME_W-1:0];
        rem_b_q <= step_b[TIME_W-1:0];
        q_a_q   <= {q_a_q[RATE_W-2:0], step_a[TIME_W]};
        q_b_q   <= {q_b_q[RATE_W-2:0], step_b[TIME_W]};
        sh_a_q  <= sh_a_q << 1;
        sh_b_q  <= sh_b_q << 1;
        cnt_q   <= cnt_q - 1'b1;
      end
      S_USETUP: begin
        // numerator is (rx + tx) << 8; top 24 bits seed the remainder
        rx_rate_q   <= rx_rate_d;
        tx_rate_q   <= tx_rate_d;
        util_zero_q <= (cap_q == '0);
        ovf_u_q     <= (rate_sum[RATE_W:9] >= 24'(cap_q));
        rem_a_q     <= TIME_W'(rate_sum[RATE_W:9]);
        sh_a_q      <= {rate_sum[8:0], 23'd0};
        q_a_q       <= '0;
        dvs_q       <= TIME_W'(cap_q);
        cnt_q       <= CNT_W'(UTIL_W - 1);
      end
      S_UTIL: begin
        rem_a_q <= step_a[TIME_W-1:0];
        q_a_q   <= {q_a_q[RATE_W-2:0], step_a[TIME_W]};
        sh_a_q  <= sh_a_q << 1;
        cnt_q   <= cnt_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      entry_valid_q <= '0;
      out_valid_o   <= 1'b0;
      link_out_o    <= '0;
      rx_rate_o     <= '0;
      tx_rate_o     <= '0;
      utilization_o <= '0;
      rate_valid_o  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          entry_valid_q[link_q] <= 1'b1;
          state_q               <= S_SETUP;
        end
        S_SETUP: begin
          state_q <= ok_q ? S_RATE : S_DONE;
        end
        S_RATE: begin
          if (cnt_q == '0) begin
            state_q <= S_USETUP;
          end
        end
        S_USETUP: begin
          state_q <= (cap_q == '0) ? S_DONE : S_UTIL;
        end
        S_UTIL: begin
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            link_out_o    <= link_q;
            rx_rate_o     <= rx_rate_q;
            tx_rate_o     <= tx_rate_q;
            utilization_o <= util_d;
            rate_valid_o  <= ok_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_READ)
    else $error("input beat did not start a memory read");

  a_rate_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RATE && cnt_q != '0) |=> state_q == S_RATE)
    else $error("rate division left early");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rate_valid_o) |->
      (rx_rate_o == '0 && tx_rate_o == '0 && utilization_o == '0))
    else $error("nonzero result without a valid rate");

  a_util_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> utilization_o <= UTIL_ONE)
    else $error("utilization above one");

endmodule
